FILE: rtl/adaptive_binary_arith_encoder_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef ADAPTIVE_BINARY_ARITH_ENCODER_DEFINES_SVH
`define ADAPTIVE_BINARY_ARITH_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ABAE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("encoder assertion failed");
// Property checked on every clock edge, reset included.
`define ABAE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("encoder assertion failed");
`else
`define ABAE_ASSERT(lbl, clk, rst_n, prop)
`define ABAE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/abae_pkg.sv
// Shared constants and types of the adaptive binary arithmetic encoder.
`timescale 1ns / 1ps
package abae_pkg;

  localparam int unsigned CONTEXT_BITS       = 12;
  localparam int unsigned PROB_FRACTION_BITS = 24;

  // Probability table geometry.
  localparam int unsigned CTX_W     = (CONTEXT_BITS > 0) ? CONTEXT_BITS : 1;
  localparam int unsigned TBL_DEPTH = 2 ** CONTEXT_BITS;

  // Probability and product widths.
  localparam int unsigned PW    = PROB_FRACTION_BITS;
  localparam int unsigned MUL_W = 33 + PW;
  localparam int unsigned LEN_SHL = 32 - PW;
  localparam int unsigned FLR_SHL = (PW >= 24) ? PW - 24 : 0;
  localparam int unsigned FLR_SHR = (PW >= 24) ? 0 : 24 - PW;

  // Register widths.
  localparam int unsigned RATE_W  = 17;
  localparam int unsigned FLOOR_W = 23;
  localparam int unsigned CFG_W   = 23;

  // Reset values of the registers.
  localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd45875;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 23'd168;
  localparam logic [RATE_W-1:0]  RATE_ONE    = 17'd65536;

  // Results kept per input item.
  localparam int unsigned RES_W = 7;
  localparam logic [RES_W-1:0] MAX_RESULTS = 7'd64;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ADAPT_RATE = 1'b0,
    CFG_FLOOR_PROB = 1'b1
  } cfg_index_e;

endpackage

FILE: rtl/abae_in_if.sv
// Input channel of the encoder: data bytes and end markers.
`timescale 1ns / 1ps
interface abae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

FILE: rtl/abae_out_if.sv
// Output channel of the encoder: packed code bytes and stream status.
`timescale 1ns / 1ps
interface abae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_run;
  logic       stream_done;
  logic [7:0] length_mod_256;
  logic       has_byte;

  modport source (output valid, output code_byte, output last_of_run, output stream_done,
                  output length_mod_256, output has_byte, input ready);
  modport sink (input valid, input code_byte, input last_of_run, input stream_done,
                input length_mod_256, input has_byte, output ready);
endinterface

FILE: rtl/abae_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module abae_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Registered read; a write to the read address returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/adaptive_binary_arith_encoder.sv
// Adaptive binary arithmetic encoder: top level with the coding sequencer.
`timescale 1ns / 1ps
`include "adaptive_binary_arith_encoder_defines.svh"
// Each data byte is coded least significant bit first. A bit goes through the
// probability table read, the two partial products of the interval split, the update and
// the adaptation write-back through the one shared multiplier and the table port, then
// through the renormalization steps, which release the settled code bits (including
// pending bits) and close each release. An end item releases the final bit and its
// pending bits, then delivers any held byte and the final result. After reset and
// after every end item the probability table is swept back to one half, one entry per
// cycle over all 2**CONTEXT_BITS (4096) entries, during which no input item is taken;
// register writes are taken at any time. One result waits in the output register while
// the next is held back until it is known whether it is the last one of its item.
module adaptive_binary_arith_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  abae_in_if.sink                        in_ch,
  abae_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_index_i,
  input  logic [abae_pkg::CFG_W-1:0]     cfg_data_i
);
  localparam int unsigned P  = abae_pkg::PW;
  localparam int unsigned CW = abae_pkg::CTX_W;
  localparam int unsigned MW = abae_pkg::MUL_W;
  localparam logic [CW-1:0] TBL_LAST = CW'(abae_pkg::TBL_DEPTH - 1);
  localparam logic [P:0]    PROB_ONE = {1'b1, {P{1'b0}}};
  localparam logic [P-1:0]  PROB_MAX = {P{1'b1}};
  localparam logic [P-1:0]  PROB_HALF = {1'b1, {(P-1){1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BIT_RD, S_MUL_HI, S_MUL_LO, S_SPLIT, S_APPLY, S_ADAPT,
    S_RENORM, S_EMIT, S_FIN_DATA, S_FLUSH
  } state_e;

  state_e state_q, state_d;

  // Registers and stream state.
  logic [abae_pkg::RATE_W-1:0]  rate_q;
  logic [abae_pkg::FLOOR_W-1:0] floor_q;
  logic [CW-1:0] ctx_q, ctx_d, clr_q, clr_d;
  logic [63:0]   low_q, low_d, high_q, high_d, len_q, len_d;
  logic [63:0]   acc_q, acc_d, split_q, split_d;
  logic [15:0]   pend_q, pend_d;
  logic [7:0]    pack_buf_q, pack_buf_d, seen_q, seen_d, byte_q, byte_d;
  logic [2:0]    pack_cnt_q, pack_cnt_d, bit_idx_q, bit_idx_d;
  logic          end_q, end_d, emit_b_q, emit_b_d, first_q, first_d;
  logic [P-1:0]  p_q, p_d;
  logic [MW-1:0] prod_q, prod_d, adapt_q, adapt_d;
  logic [abae_pkg::RES_W-1:0] res_cnt_q, res_cnt_d;
  logic          hold_valid_q, hold_valid_d;
  logic [7:0]    hold_byte_q, hold_byte_d;

  // Output register.
  logic       out_valid_q, out_valid_d, out_last_q, out_last_d, out_done_q, out_done_d;
  logic       out_has_q, out_has_d;
  logic [7:0] out_byte_q, out_byte_d, out_len_q, out_len_d;

  // Table port and shared multiplier.
  logic          ram_we;
  logic [CW-1:0] ram_addr;
  logic [P-1:0]  ram_wdata, ram_rdata;
  logic [31:0]   mul_a;
  logic [P:0]    mul_b;
  logic [MW-1:0] mul_prod;

  // Adaptation arithmetic.
  logic [abae_pkg::RATE_W-1:0] rate_eff, rate_inv;
  logic [63:0] flr_wide;
  logic [P:0]  flr, target;
  logic [MW:0] np_sum, np_shift;
  logic [P-1:0] np_new;

  logic in_fire, out_free, cur_bit, pbit, push_blocked;
  logic [7:0] new_byte;

  abae_ram #(.WIDTH(P), .DEPTH(abae_pkg::TBL_DEPTH)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ch.ready;

  assign out_ch.valid          = out_valid_q;
  assign out_ch.code_byte      = out_byte_q;
  assign out_ch.last_of_run    = out_last_q;
  assign out_ch.stream_done    = out_done_q;
  assign out_ch.length_mod_256 = out_len_q;
  assign out_ch.has_byte       = out_has_q;

  assign mul_prod = {{(P + 1){1'b0}}, mul_a} * {{32{1'b0}}, mul_b};
  assign cur_bit  = end_q ? 1'b1 : byte_q[bit_idx_q];

  // Learning rate saturates at one; the floor is rescaled to the probability format.
  assign rate_eff = (rate_q > abae_pkg::RATE_ONE) ? abae_pkg::RATE_ONE : rate_q;
  assign rate_inv = abae_pkg::RATE_ONE - rate_eff;
  assign flr_wide = (64'(floor_q) << abae_pkg::FLR_SHL) >> abae_pkg::FLR_SHR;
  assign flr      = (flr_wide > 64'(PROB_ONE)) ? PROB_ONE : flr_wide[P:0];
  assign target   = cur_bit ? flr : (PROB_ONE - flr);

  // New probability, clamped to the open unit interval.
  assign np_sum   = {1'b0, adapt_q} + {1'b0, prod_q};
  assign np_shift = np_sum >> 16;
  always_comb begin
    if (np_shift == '0) begin
      np_new = P'(1);
    end else if (np_shift > (MW + 1)'(PROB_MAX)) begin
      np_new = PROB_MAX;
    end else begin
      np_new = np_shift[P-1:0];
    end
  end

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= abae_pkg::RATE_RESET;
      floor_q <= abae_pkg::FLOOR_RESET;
    end else if (cfg_we_i) begin
      case (abae_pkg::cfg_index_e'(cfg_index_i))
        abae_pkg::CFG_ADAPT_RATE: rate_q  <= cfg_data_i[abae_pkg::RATE_W-1:0];
        abae_pkg::CFG_FLOOR_PROB: floor_q <= cfg_data_i[abae_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d = state_q;
    ctx_d = ctx_q; clr_d = clr_q; low_d = low_q; high_d = high_q; len_d = len_q;
    acc_d = acc_q; split_d = split_q; pend_d = pend_q; pack_buf_d = pack_buf_q;
    seen_d = seen_q; byte_d = byte_q; pack_cnt_d = pack_cnt_q; bit_idx_d = bit_idx_q;
    end_d = end_q; emit_b_d = emit_b_q; first_d = first_q; p_d = p_q;
    prod_d = prod_q; adapt_d = adapt_q; res_cnt_d = res_cnt_q;
    hold_valid_d = hold_valid_q; hold_byte_d = hold_byte_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_last_d = out_last_q; out_done_d = out_done_q; out_has_d = out_has_q;
    out_byte_d = out_byte_q; out_len_d = out_len_q;
    ram_we = 1'b0;
    ram_addr = (state_q == S_CLEAR) ? clr_q : ctx_q;
    ram_wdata = (state_q == S_CLEAR) ? PROB_HALF : np_new;
    mul_a = '0;
    mul_b = '0;
    pbit = first_q ? emit_b_q : !emit_b_q;
    new_byte = pack_buf_q | (8'(pbit) << pack_cnt_q);
    push_blocked = (res_cnt_q < abae_pkg::MAX_RESULTS) && hold_valid_q && !out_free;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d = clr_q + CW'(1);
        if (clr_q == TBL_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          byte_d = in_ch.data_byte;
          end_d = in_ch.end_of_data;
          res_cnt_d = '0;
          bit_idx_d = '0;
          if (in_ch.end_of_data) begin
            emit_b_d = 1'b1;
            first_d = 1'b1;
            state_d = S_EMIT;
          end else begin
            seen_d = seen_q + 8'd1;
            state_d = S_BIT_RD;
          end
        end
      end
      S_BIT_RD: begin
        len_d = high_q - low_q;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        p_d = ram_rdata;
        mul_a = len_q[63:32];
        mul_b = {1'b0, ram_rdata};
        prod_d = mul_prod;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        acc_d = 64'(prod_q) << abae_pkg::LEN_SHL;
        mul_a = len_q[31:0];
        mul_b = {1'b0, p_q};
        prod_d = mul_prod;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        split_d = acc_q + 64'(prod_q >> P);
        mul_a = 32'(rate_eff);
        mul_b = {1'b0, p_q};
        prod_d = mul_prod;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (cur_bit) begin
          low_d = low_q + split_q + 64'd1;
        end else begin
          high_d = low_q + split_q;
        end
        adapt_d = prod_q;
        mul_a = 32'(rate_inv);
        mul_b = target;
        prod_d = mul_prod;
        state_d = S_ADAPT;
      end
      S_ADAPT: begin
        ram_we = 1'b1;
        ctx_d = (abae_pkg::CONTEXT_BITS == 0) ? '0 : CW'({ctx_q, cur_bit});
        state_d = S_RENORM;
      end
      S_RENORM: begin
        if (!high_q[63] || low_q[63]) begin
          // Interval in one half: shift out a settled bit.
          low_d = {low_q[62:0], 1'b0};
          high_d = {high_q[62:0], 1'b1};
          emit_b_d = low_q[63];
          first_d = 1'b1;
          state_d = S_EMIT;
        end else if (low_q[62] && !high_q[62]) begin
          // Interval straddles the middle: defer the bit.
          low_d = {1'b0, low_q[61:0], 1'b0};
          high_d = {1'b1, high_q[61:0], 1'b1};
          if (pend_q != 16'hFFFF) begin
            pend_d = pend_q + 16'd1;
          end
        end else if (bit_idx_q == 3'd7) begin
          state_d = S_FIN_DATA;
        end else begin
          bit_idx_d = bit_idx_q + 3'd1;
          state_d = S_BIT_RD;
        end
      end
      S_EMIT: begin
        if (first_q || pend_q != '0) begin
          if (!(pack_cnt_q == 3'd7 && push_blocked)) begin
            if (pack_cnt_q == 3'd7) begin
              pack_buf_d = '0;
              pack_cnt_d = '0;
              if (res_cnt_q < abae_pkg::MAX_RESULTS) begin
                if (hold_valid_q) begin
                  out_valid_d = 1'b1;
                  out_byte_d = hold_byte_q;
                  out_last_d = 1'b0;
                  out_done_d = 1'b0;
                  out_has_d = 1'b1;
                  out_len_d = '0;
                end
                hold_byte_d = new_byte;
                hold_valid_d = 1'b1;
                res_cnt_d = res_cnt_q + abae_pkg::RES_W'(1);
              end
            end else begin
              pack_buf_d = new_byte;
              pack_cnt_d = pack_cnt_q + 3'd1;
            end
            if (first_q) begin
              first_d = 1'b0;
            end else begin
              pend_d = pend_q - 16'd1;
            end
          end
        end else begin
          state_d = end_q ? S_FLUSH : S_RENORM;
        end
      end
      S_FIN_DATA: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d = hold_byte_q;
          out_last_d = 1'b1;
          out_done_d = 1'b0;
          out_has_d = 1'b1;
          out_len_d = '0;
          hold_valid_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (hold_valid_q && res_cnt_q < abae_pkg::MAX_RESULTS) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d = hold_byte_q;
            out_last_d = 1'b0;
            out_done_d = 1'b0;
            out_has_d = 1'b1;
            out_len_d = '0;
            hold_valid_d = 1'b0;
          end
        end else if (out_free) begin
          // Final result; it replaces a held byte once the result limit is reached.
          out_valid_d = 1'b1;
          out_byte_d = (pack_cnt_q != '0) ? pack_buf_q : 8'd0;
          out_has_d = (pack_cnt_q != '0);
          out_last_d = 1'b1;
          out_done_d = 1'b1;
          out_len_d = seen_q;
          hold_valid_d = 1'b0;
          ctx_d = '0;
          low_d = '0;
          high_d = '1;
          pend_d = '0;
          pack_buf_d = '0;
          pack_cnt_d = '0;
          seen_d = '0;
          clr_d = '0;
          state_d = S_CLEAR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      ctx_q <= '0;
      low_q <= '0;
      high_q <= '1;
      pend_q <= '0;
      pack_buf_q <= '0;
      pack_cnt_q <= '0;
      seen_q <= '0;
      end_q <= 1'b0;
      first_q <= 1'b0;
      bit_idx_q <= '0;
      res_cnt_q <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      ctx_q <= ctx_d;
      low_q <= low_d;
      high_q <= high_d;
      pend_q <= pend_d;
      pack_buf_q <= pack_buf_d;
      pack_cnt_q <= pack_cnt_d;
      seen_q <= seen_d;
      end_q <= end_d;
      first_q <= first_d;
      bit_idx_q <= bit_idx_d;
      res_cnt_q <= res_cnt_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q <= out_valid_d;
      out_last_q <= out_last_d;
      out_done_q <= out_done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    acc_q <= acc_d;
    split_q <= split_d;
    byte_q <= byte_d;
    emit_b_q <= emit_b_d;
    p_q <= p_d;
    prod_q <= prod_d;
    adapt_q <= adapt_d;
    hold_byte_q <= hold_byte_d;
    out_byte_q <= out_byte_d;
    out_len_q <= out_len_d;
    out_has_q <= out_has_d;
  end

  // A new item never finds a result still held back from the previous one.
  `ABAE_ASSERT(a_idle_hold_empty, clk_i, rst_ni, in_fire |-> !hold_valid_q)
  // A held result has been counted.
  `ABAE_ASSERT(a_hold_counted, clk_i, rst_ni, hold_valid_q |-> (res_cnt_q != '0))
  // The per-item result count stops at the limit.
  `ABAE_ASSERT(a_res_limit, clk_i, rst_ni, res_cnt_q <= abae_pkg::MAX_RESULTS)
  // The stream's final result always closes its item.
  `ABAE_ASSERT(a_done_is_last, clk_i, rst_ni, (out_valid_q && out_done_q) |-> out_last_q)
  // The table write-back is followed by renormalization.
  `ABAE_ASSERT(a_adapt_then_renorm, clk_i, rst_ni, (state_q == S_ADAPT) |=> (state_q == S_RENORM))
endmodule

FILE: test/tb.sv
// Self-checking testbench for the adaptive binary arithmetic encoder.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } sym_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_run;
    logic       stream_done;
    logic [7:0] length_mod_256;
    logic       has_byte;
  } code_t;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned DRAIN_WAIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] HALF_PT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QTR_PT   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] TQTR_PT  = 64'hC000_0000_0000_0000;
  localparam logic [63:0] P_ONE    = 64'd1 << abae_pkg::PROB_FRACTION_BITS;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [abae_pkg::CFG_W-1:0] cfg_data;

  abae_in_if  in_ch ();
  abae_out_if out_ch ();

  adaptive_binary_arith_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Encoder mirror state.
  logic [23:0] zprob [abae_pkg::TBL_DEPTH];
  logic [11:0] ctx_hist;
  logic [63:0] iv_low, iv_high;
  int unsigned pend_bits;
  logic [7:0]  pk_buf;
  int unsigned pk_cnt;
  logic [7:0]  nbytes;
  logic [16:0] rate_reg;
  logic [22:0] floor_reg;

  code_t item_codes[$];
  code_t code_fifo[$];
  sym_t  sym_fifo[$];

  int unsigned errors;
  int unsigned idle_cnt;
  logic in_taken, out_taken;
  bit   send_quiet, recv_quiet;
  int unsigned hold_req, hold_seen, hold_left;
  int unsigned send_gap, recv_gap;

  function void clear_stream();
    for (int i = 0; i < abae_pkg::TBL_DEPTH; i++) zprob[i] = 24'h800000;
    ctx_hist  = '0;
    iv_low    = '0;
    iv_high   = '1;
    pend_bits = 0;
    pk_buf    = '0;
    pk_cnt    = 0;
    nbytes    = '0;
  endfunction

  function void add_code(logic [7:0] cb, logic has, logic done, logic [7:0] len);
    code_t r;
    r = '{code_byte: cb, last_of_run: 1'b0, stream_done: done,
          length_mod_256: len, has_byte: has};
    // Bytes past the per-item cap are dropped; the final one takes the last slot.
    if (item_codes.size() >= abae_pkg::MAX_RESULTS) begin
      if (done) item_codes[abae_pkg::MAX_RESULTS-1] = r;
    end else begin
      item_codes.push_back(r);
    end
  endfunction

  function void pack_bit(logic b);
    pk_buf[pk_cnt[2:0]] = b;
    pk_cnt++;
    if (pk_cnt >= 8) begin
      add_code(pk_buf, 1'b1, 1'b0, 8'd0);
      pk_buf = '0;
      pk_cnt = 0;
    end
  endfunction

  function void emit_bit(logic b);
    pack_bit(b);
    while (pend_bits > 0) begin
      pend_bits--;
      pack_bit(~b);
    end
  endfunction

  function void code_bit(logic b);
    logic [11:0] idx;
    logic [63:0] prb, span, a_prod, b_prod, split, rt, flr, tgt, np;
    bit          busy;
    idx    = ctx_hist;
    prb    = {40'd0, zprob[idx]};
    span   = iv_high - iv_low;
    a_prod = (span >> 32) * prb;
    b_prod = {32'd0, span[31:0]} * prb;
    split  = (a_prod << abae_pkg::LEN_SHL) + (b_prod >> abae_pkg::PW);
    if (!b) iv_high = iv_low + split;
    else iv_low = iv_low + split + 64'd1;

    // Renormalize with the three scaling cases.
    busy = 1'b1;
    while (busy) begin
      if (iv_high < HALF_PT) begin
        iv_low  = iv_low << 1;
        iv_high = (iv_high << 1) | 64'd1;
        emit_bit(1'b0);
      end else if (iv_low >= HALF_PT) begin
        iv_low  = (iv_low - HALF_PT) << 1;
        iv_high = ((iv_high - HALF_PT) << 1) | 64'd1;
        emit_bit(1'b1);
      end else if (iv_low >= QTR_PT && iv_high < TQTR_PT) begin
        iv_low  = (iv_low - QTR_PT) << 1;
        iv_high = ((iv_high - QTR_PT) << 1) | 64'd1;
        if (pend_bits < 65535) pend_bits++;
      end else begin
        busy = 1'b0;
      end
    end

    // Move the probability toward its target.
    rt  = (rate_reg > abae_pkg::RATE_ONE) ? 64'd65536 : {47'd0, rate_reg};
    flr = {41'd0, floor_reg};
    if (flr > P_ONE) flr = P_ONE;
    tgt = b ? flr : (P_ONE - flr);
    np  = (prb * rt + tgt * (64'd65536 - rt)) >> 16;
    if (np < 64'd1) np = 64'd1;
    if (np > P_ONE - 64'd1) np = P_ONE - 64'd1;
    zprob[idx] = np[23:0];
    ctx_hist = {ctx_hist[10:0], b};
  endfunction

  function void encode_symbol(sym_t s);
    item_codes.delete();
    if (s.end_of_data) begin
      emit_bit(1'b1);
      if (pk_cnt > 0) add_code(pk_buf, 1'b1, 1'b1, nbytes);
      else add_code(8'd0, 1'b0, 1'b1, nbytes);
      clear_stream();
    end else begin
      nbytes = nbytes + 8'd1;
      for (int j = 0; j < 8; j++) code_bit(s.data_byte[j]);
    end
    if (item_codes.size() > 0) item_codes[item_codes.size()-1].last_of_run = 1'b1;
    foreach (item_codes[k]) code_fifo.push_back(item_codes[k]);
  endfunction

  // Input driver: presents queued items with random gaps.
  always @(negedge clk_i) begin : drv
    sym_t s;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the current item until it is taken.
    end else if (send_gap > 0) begin
      send_gap--;
      in_ch.valid <= 1'b0;
    end else if (sym_fifo.size() > 0) begin
      s = sym_fifo.pop_front();
      in_ch.data_byte   <= s.data_byte;
      in_ch.end_of_data <= s.end_of_data;
      in_ch.valid       <= 1'b1;
      send_gap = send_quiet ? 0 : $urandom_range(0, 10);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Output receiver: random stalls per transaction, plus requested long holds.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (out_taken) recv_gap = recv_quiet ? 0 : $urandom_range(0, 10);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_ni;
    end
  end

  // Monitor: predicts on input transactions, checks output transactions.
  always @(posedge clk_i) begin : mon
    code_t want;
    in_taken  <= in_ch.valid && in_ch.ready;
    out_taken <= out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      idle_cnt++;
      if (in_ch.valid && in_ch.ready) begin
        idle_cnt = 0;
        encode_symbol('{data_byte: in_ch.data_byte, end_of_data: in_ch.end_of_data});
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cnt = 0;
        if (code_fifo.size() == 0) begin
          $error("unexpected output transaction, code_byte %0h", out_ch.code_byte);
          errors++;
        end else begin
          want = code_fifo.pop_front();
          if (out_ch.code_byte !== want.code_byte) begin
            $error("code_byte: expected %0h, got %0h", want.code_byte, out_ch.code_byte);
            errors++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_ch.last_of_run);
            errors++;
          end
          if (out_ch.stream_done !== want.stream_done) begin
            $error("stream_done: expected %0d, got %0d", want.stream_done,
                   out_ch.stream_done);
            errors++;
          end
          if (out_ch.length_mod_256 !== want.length_mod_256) begin
            $error("length_mod_256: expected %0d, got %0d", want.length_mod_256,
                   out_ch.length_mod_256);
            errors++;
          end
          if (out_ch.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0d, got %0d", want.has_byte, out_ch.has_byte);
            errors++;
          end
        end
      end
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_sym(logic [7:0] d, logic eod);
    sym_fifo.push_back('{data_byte: d, end_of_data: eod});
  endtask

  // Wait until every item is taken and every code byte is seen, then let it settle.
  task automatic wait_drained();
    while (sym_fifo.size() > 0 || in_ch.valid || code_fifo.size() > 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(abae_pkg::cfg_index_e idx, logic [abae_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      abae_pkg::CFG_ADAPT_RATE: rate_reg  = val[abae_pkg::RATE_W-1:0];
      abae_pkg::CFG_FLOOR_PROB: floor_reg = val[abae_pkg::FLOOR_W-1:0];
      default: ;
    endcase
  endtask

  // Random stream: skewed runs of one byte pattern, random bytes and end items.
  task automatic random_phase(int unsigned n);
    logic [7:0] pat;
    int unsigned r;
    pat = 8'($urandom_range(0, 255));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) queue_sym(8'($urandom_range(0, 255)), 1'b1);
      else if (r < 55) queue_sym(pat, 1'b0);
      else queue_sym(8'($urandom_range(0, 255)), 1'b0);
    end
    queue_sym(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = abae_pkg::CFG_ADAPT_RATE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.end_of_data = 1'b0;
    out_ch.ready      = 1'b0;
    in_taken          = 1'b0;
    out_taken         = 1'b0;
    errors = 0; idle_cnt = 0; send_gap = 0; recv_gap = 0;
    hold_req = 0; hold_seen = 0; hold_left = 0;
    send_quiet = 1'b0; recv_quiet = 1'b0;
    rate_reg  = abae_pkg::RATE_RESET;
    floor_reg = abae_pkg::FLOOR_RESET;
    clear_stream();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, bit patterns, and back-to-back ends.
    queue_sym(8'h00, 1'b0);
    queue_sym(8'hFF, 1'b0);
    queue_sym(8'h55, 1'b0);
    queue_sym(8'hAA, 1'b0);
    queue_sym(8'h01, 1'b0);
    queue_sym(8'h80, 1'b0);
    queue_sym(8'hFF, 1'b1);
    queue_sym(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) queue_sym(8'h00, 1'b0);
    queue_sym(8'h5A, 1'b1);
    wait_drained();

    // Fastest learning with the smallest nonzero floor, long receiver hold.
    write_reg(abae_pkg::CFG_ADAPT_RATE, 23'd655);
    write_reg(abae_pkg::CFG_FLOOR_PROB, 23'd1);
    send_quiet = 1'b1;
    hold_req++;
    random_phase(18);
    wait_drained();
    send_quiet = 1'b0;

    // Rate of exactly one with the largest floor.
    write_reg(abae_pkg::CFG_ADAPT_RATE, 23'd65536);
    write_reg(abae_pkg::CFG_FLOOR_PROB, 23'd8388607);
    recv_quiet = 1'b1;
    random_phase(18);
    wait_drained();
    recv_quiet = 1'b0;

    // Rate above one saturates; zero floor.
    write_reg(abae_pkg::CFG_ADAPT_RATE, 23'd131071);
    write_reg(abae_pkg::CFG_FLOOR_PROB, 23'd0);
    random_phase(18);
    wait_drained();

    // Random mid-range settings.
    for (int k = 0; k < 2; k++) begin
      write_reg(abae_pkg::CFG_ADAPT_RATE, abae_pkg::CFG_W'($urandom_range(655, 65536)));
      write_reg(abae_pkg::CFG_FLOOR_PROB, abae_pkg::CFG_W'($urandom_range(1, 8388607)));
      send_quiet = k[0];
      random_phase(16);
      wait_drained();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
